// File: rtl/core/msfl_pkg.sv
`default_nettype none

package msfl_pkg;

    localparam int SLOTS_DEF  = 16;
    localparam int STACKS_DEF = 4;
    localparam int VALUE_W    = 32;
    localparam int SID_W      = 2;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic                       req_type;
        logic [SID_W-1:0]           stack_id;
        logic signed [VALUE_W-1:0]  push_value;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  pop_value;
        logic [1:0]                 status;
        logic                       store_full;
        logic                       stack_empty;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // input transfer: latch request, read stack top
        logic lookup;    // read link and value of the addressed slot
        logic commit;    // update pointers and memories, load result
    } msfl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;  // result register can take a new result this cycle
    } msfl_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/msfl_ctrl.sv
`default_nettype none

module msfl_ctrl
    import msfl_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire msfl_sts_t sts,
    output msfl_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WRITE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   commit;
    logic   accept;

    assign commit   = (state_reg == S_WRITE) && sts.out_free;
    // a new request may enter in the same cycle the previous one commits
    assign in_ready = (state_reg == S_IDLE) || commit;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd.capture = accept;
        cmd.lookup  = (state_reg == S_READ);
        cmd.commit  = commit;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (commit)
                    state_next = accept ? S_READ : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/msfl_datapath.sv
`default_nettype none

module msfl_datapath
    import msfl_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int STACKS = STACKS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire msfl_cmd_t cmd,
    output msfl_sts_t      sts,
    input  wire req_t      in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output rsp_t           out_data
);

    localparam int PW = $clog2(SLOTS + 1);              // slot pointer, SLOTS = null
    localparam int IW = $clog2(SLOTS);                  // slot index
    localparam int TW = (STACKS > 1) ? $clog2(STACKS) : 1;
    localparam logic [PW-1:0] NULL_PTR = PW'(SLOTS);

    // slot stores
    logic [VALUE_W-1:0] val_mem  [SLOTS];
    logic [PW-1:0]      link_mem [SLOTS];
    logic [PW-1:0]      tops_mem [STACKS];
    logic [STACKS-1:0]  tops_vld_reg;

    req_t               req_reg;
    logic [PW-1:0]      free_head_reg;
    logic [PW-1:0]      free_head_next;
    // slots at or above the watermark were never taken: their link is index + 1
    logic [PW-1:0]      fresh_reg;

    logic [PW-1:0]      top_raw_reg;
    logic               top_vld_reg;
    logic               top_fwd_reg;
    logic [PW-1:0]      top_fwd_val_reg;
    logic [PW-1:0]      link_rd_reg;
    logic [VALUE_W-1:0] val_rd_reg;

    logic               out_valid_reg;
    rsp_t               out_data_reg;

    logic [TW-1:0]      rd_idx;
    logic [TW-1:0]      wr_idx;
    logic [PW-1:0]      top;
    logic               sid_ok;
    logic               is_pop;
    logic               top_null;
    logic               head_null;
    logic               head_fresh;
    logic               push_ok;
    logic               pop_ok;
    logic [PW-1:0]      slot_addr;
    logic [PW-1:0]      new_top;
    logic               tops_we;
    logic               slot_we;
    logic [PW-1:0]      link_wdata;
    status_t            status;
    rsp_t               rsp;

    assign rd_idx = TW'(in_data.stack_id);
    assign wr_idx = TW'(req_reg.stack_id);

    assign top = top_fwd_reg ? top_fwd_val_reg : (top_vld_reg ? top_raw_reg : NULL_PTR);

    always_comb
    begin
        sid_ok     = (32'(req_reg.stack_id) < 32'(STACKS));
        is_pop     = (req_reg.req_type == REQ_POP);
        top_null   = (top >= NULL_PTR);
        head_null  = (free_head_reg >= NULL_PTR);
        head_fresh = (free_head_reg >= fresh_reg);
        push_ok    = sid_ok && !is_pop && !head_null;
        pop_ok     = sid_ok && is_pop && !top_null;
        slot_addr  = is_pop ? top : free_head_reg;

        new_top        = top;
        free_head_next = free_head_reg;
        link_wdata     = top;
        if (push_ok)
        begin
            new_top        = free_head_reg;
            free_head_next = head_fresh ? (free_head_reg + PW'(1)) : link_rd_reg;
            link_wdata     = top;
        end
        else if (pop_ok)
        begin
            new_top        = link_rd_reg;
            free_head_next = top;
            link_wdata     = free_head_reg;
        end

        if (!sid_ok)
            status = is_pop ? STATUS_UNDERFLOW : STATUS_OVERFLOW;
        else if (!is_pop && head_null)
            status = STATUS_OVERFLOW;
        else if (is_pop && top_null)
            status = STATUS_UNDERFLOW;
        else
            status = STATUS_OK;

        rsp.pop_value   = pop_ok ? val_rd_reg : '0;
        rsp.status      = status;
        rsp.store_full  = (free_head_next >= NULL_PTR);
        rsp.stack_empty = !sid_ok || (new_top >= NULL_PTR);

        slot_we = cmd.commit && (push_ok || pop_ok);
        tops_we = slot_we;
    end

    // request and pointer registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= '0;
            fresh_reg     <= '0;
        end
        else if (cmd.commit)
        begin
            free_head_reg <= free_head_next;
            if (push_ok && head_fresh)
                fresh_reg <= fresh_reg + PW'(1);
        end
    end

    // stack top store; a top written by the committing request is forwarded
    always_ff @(posedge clk)
    begin
        if (tops_we)
            tops_mem[wr_idx] <= new_top;
        if (cmd.capture)
            top_raw_reg <= tops_mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tops_vld_reg    <= '0;
            top_vld_reg     <= 1'b0;
            top_fwd_reg     <= 1'b0;
            top_fwd_val_reg <= '0;
        end
        else
        begin
            if (tops_we)
                tops_vld_reg[wr_idx] <= 1'b1;
            if (cmd.capture)
            begin
                top_vld_reg     <= tops_vld_reg[rd_idx];
                top_fwd_reg     <= tops_we && (wr_idx == rd_idx);
                top_fwd_val_reg <= new_top;
            end
        end
    end

    // slot link and value stores
    always_ff @(posedge clk)
    begin
        if (slot_we)
            link_mem[slot_addr[IW-1:0]] <= link_wdata;
        if (cmd.lookup)
            link_rd_reg <= link_mem[slot_addr[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we && !is_pop)
            val_mem[slot_addr[IW-1:0]] <= req_reg.push_value;
        if (cmd.lookup)
            val_rd_reg <= val_mem[slot_addr[IW-1:0]];
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            out_data_reg <= rsp;
    end

    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;
    assign sts.out_free = !out_valid_reg || out_ready;

    a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_head_reg <= NULL_PTR)
        else $error("free head beyond null");

    a_head_below_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        free_head_reg <= fresh_reg)
        else $error("free head above never-used watermark");

    a_fresh_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> fresh_reg >= $past(fresh_reg))
        else $error("watermark moved down");

    a_underflow_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.status == STATUS_UNDERFLOW)
        |-> (out_data_reg.pop_value == '0) && out_data_reg.stack_empty)
        else $error("underflow result carries data or nonempty stack");

endmodule

`default_nettype wire

// File: rtl/core/multi_stack_free_list.sv
// Request and stack top are latched at the input transfer; the dependent slot
// link/value read follows in S_READ, and the result is registered at commit in
// S_WRITE once the result register is free; the commit overlaps the next transfer.
// Reset (rst_n, async): stacks empty, free list 0..SLOTS-1, result register empty;
// slot links come from a never-used watermark, so no clearing pass is run.
`default_nettype none

module multi_stack_free_list
    import msfl_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int STACKS = STACKS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire req_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output rsp_t      out_data
);

    msfl_cmd_t cmd;
    msfl_sts_t sts;

    msfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    msfl_datapath #(
        .SLOTS  (SLOTS),
        .STACKS (STACKS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
